>>> src/range_assign_range_sum_tree_assert.svh
// assertion macros used by the port checker
`ifndef RANGE_ASSIGN_RANGE_SUM_TREE_ASSERT_SVH
`define RANGE_ASSIGN_RANGE_SUM_TREE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RTSS_ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RTSS_ASSERT_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

>>> src/rtss_pkg.sv
// shared types and constants for the range assign / range sum tree
package rtss_pkg;

    localparam int DEF_SIZE = 1024;
    localparam int SUM_W    = 42;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = 10;

    localparam logic REQ_ASSIGN = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic                    pend;
        logic signed [VAL_W-1:0] pval;
        logic [SUM_W-1:0]        sum;
    } node_t;

    typedef enum logic {
        ALU_FILL,
        ALU_ADD
    } alu_op_t;

endpackage

>>> src/rtss_mem.sv
// node memory, one write and one registered read per cycle
module rtss_mem
    import rtss_pkg::*;
#(
    parameter int AW = 11
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  node_t         wdata,
    input  logic [AW-1:0] raddr,
    output node_t         rdata
);

    localparam int DEPTH = 1 << AW;

    node_t mem_reg [DEPTH];
    node_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/rtss_alu.sv
// shared arithmetic unit: scaled fill value or sum of two operand sums
module rtss_alu
    import rtss_pkg::*;
#(
    parameter int HW = 5
)
(
    input  alu_op_t                 op,
    input  logic signed [VAL_W-1:0] val,
    input  logic [HW-1:0]           sh,
    input  logic [SUM_W-1:0]        a,
    input  logic [SUM_W-1:0]        b,
    output logic [SUM_W-1:0]        res
);

    logic signed [SUM_W-1:0] val_ext;

    assign val_ext = SUM_W'(val);

    always_comb
    begin
        unique case (op)
            ALU_FILL: res = val_ext << sh;
            ALU_ADD:  res = a + b;
            default:  res = a + b;
        endcase
    end

endmodule

>>> src/range_assign_range_sum_tree.sv
// operation: an item walks both boundary paths of the node tree through one memory port:
// a pushed node is read, its two children written and the node written back; a covered
// node is read into the sum or filled; a rebuilt node gets the sum of its two children
// items: one at a time; a finished sum waits in an output register
// reset: after rst_n the tree is cleared one node a cycle, every memory entry in turn,
// with in_ready low until the clearing pass ends
module range_assign_range_sum_tree
    import rtss_pkg::*;
#(
    parameter int SIZE = DEF_SIZE
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [IDX_W-1:0]        range_start,
    input  logic [IDX_W-1:0]        range_end,
    input  logic signed [VAL_W-1:0] assign_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SUM_W-1:0] range_sum
);

    localparam int LOG = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int N   = 1 << LOG;
    localparam int XW  = LOG + 2;
    localparam int AW  = LOG + 1;
    localparam int HW  = $clog2(LOG + 2);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_PCHK, S_PRD, S_PW2, S_PW3, S_WL, S_WR, S_WSH,
        S_QRD, S_UCHK, S_URD1, S_URD2, S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic                    side_reg, side_next;
    logic [HW-1:0]           i_reg, i_next;
    logic [HW-1:0]           h_reg, h_next;
    logic [XW-1:0]           l_reg, l_next, r_reg, r_next;
    logic [XW-1:0]           l0_reg, l0_next, r0_reg, r0_next;
    logic                    kind_reg, kind_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [SUM_W-1:0]        acc_reg, acc_next;
    logic [SUM_W-1:0]        tmp_reg, tmp_next;
    logic [AW-1:0]           node_reg, node_next;
    node_t                   nw_reg, nw_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]        out_sum_reg, out_sum_next;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    node_t                   mem_wdata, mem_rdata;

    alu_op_t                 alu_op;
    logic signed [VAL_W-1:0] alu_val;
    logic [HW-1:0]           alu_sh;
    logic [SUM_W-1:0]        alu_a, alu_b, alu_res;

    logic [31:0]             start_w, end_w, lim_w, b_w;
    logic                    empty;
    logic [XW-1:0]           xl, xr, r_m1, low_mask;
    logic                    cond_l, cond_r, cond;
    logic [AW-1:0]           k_sel;
    logic                    push_adv, upd_adv;

    rtss_mem #(.AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rtss_alu #(.HW(HW)) u_alu (
        .op  (alu_op),
        .val (alu_val),
        .sh  (alu_sh),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // clip the range at the transfer
    assign start_w = 32'(range_start);
    assign end_w   = 32'(range_end);
    assign lim_w   = 32'(SIZE - 1);
    assign b_w     = (end_w > lim_w) ? lim_w : end_w;
    assign empty   = start_w > b_w;
    assign xl      = XW'(start_w + 32'(N));
    assign xr      = XW'(b_w + 32'(N) + 32'd1);

    // boundary node at level i and whether it needs work
    assign r_m1     = r_reg - XW'(1);
    assign low_mask = ~({XW{1'b1}} << i_reg);
    assign cond_l   = (l_reg & low_mask) != '0;
    assign cond_r   = (r_reg & low_mask) != '0;
    assign cond     = side_reg ? cond_r : cond_l;
    assign k_sel    = side_reg ? AW'(r_m1 >> i_reg) : AW'(l_reg >> i_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign range_sum = out_sum_reg;

    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        i_next         = i_reg;
        h_next         = h_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        l0_next        = l0_reg;
        r0_next        = r0_reg;
        kind_next      = kind_reg;
        val_next       = val_reg;
        acc_next       = acc_reg;
        tmp_next       = tmp_reg;
        node_next      = node_reg;
        nw_next        = nw_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;
        mem_we         = 1'b0;
        mem_waddr      = node_reg;
        mem_wdata      = '0;
        mem_raddr      = node_reg;
        alu_op         = ALU_ADD;
        alu_val        = val_reg;
        alu_sh         = h_reg;
        alu_a          = acc_reg;
        alu_b          = mem_rdata.sum;
        push_adv       = 1'b0;
        upd_adv        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = req_type;
                    val_next  = assign_value;
                    acc_next  = '0;
                    l_next    = xl;
                    r_next    = xr;
                    l0_next   = xl;
                    r0_next   = xr;
                    i_next    = HW'(LOG);
                    side_next = 1'b0;
                    if (empty)
                    begin
                        state_next = (req_type == REQ_QUERY) ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PCHK;
                    end
                end
            end
            S_PCHK:
            begin
                if (cond)
                begin
                    mem_raddr  = k_sel;
                    node_next  = k_sel;
                    state_next = S_PRD;
                end
                else
                begin
                    push_adv = 1'b1;
                end
            end
            S_PRD:
            begin
                nw_next = mem_rdata;
                if (mem_rdata.pend)
                begin
                    alu_op         = ALU_FILL;
                    alu_val        = mem_rdata.pval;
                    alu_sh         = i_reg - HW'(1);
                    mem_we         = 1'b1;
                    mem_waddr      = AW'({node_reg, 1'b0});
                    mem_wdata.pend = 1'b1;
                    mem_wdata.pval = mem_rdata.pval;
                    mem_wdata.sum  = alu_res;
                    state_next     = S_PW2;
                end
                else
                begin
                    push_adv = 1'b1;
                end
            end
            S_PW2:
            begin
                alu_op         = ALU_FILL;
                alu_val        = nw_reg.pval;
                alu_sh         = i_reg - HW'(1);
                mem_we         = 1'b1;
                mem_waddr      = AW'({node_reg, 1'b1});
                mem_wdata.pend = 1'b1;
                mem_wdata.pval = nw_reg.pval;
                mem_wdata.sum  = alu_res;
                state_next     = S_PW3;
            end
            S_PW3:
            begin
                mem_we         = 1'b1;
                mem_waddr      = node_reg;
                mem_wdata.pend = 1'b0;
                mem_wdata.pval = nw_reg.pval;
                mem_wdata.sum  = nw_reg.sum;
                push_adv       = 1'b1;
            end
            S_WL:
            begin
                if (!(l_reg < r_reg))
                begin
                    if (kind_reg == REQ_QUERY)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        l_next     = l0_reg;
                        r_next     = r0_reg;
                        i_next     = HW'(1);
                        side_next  = 1'b0;
                        state_next = S_UCHK;
                    end
                end
                else if (l_reg[0])
                begin
                    l_next = l_reg + XW'(1);
                    if (kind_reg == REQ_QUERY)
                    begin
                        mem_raddr  = AW'(l_reg);
                        side_next  = 1'b0;
                        state_next = S_QRD;
                    end
                    else
                    begin
                        alu_op         = ALU_FILL;
                        mem_we         = 1'b1;
                        mem_waddr      = AW'(l_reg);
                        mem_wdata.pend = 1'b1;
                        mem_wdata.pval = val_reg;
                        mem_wdata.sum  = alu_res;
                        state_next     = S_WR;
                    end
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                if (r_reg[0])
                begin
                    r_next = r_m1;
                    if (kind_reg == REQ_QUERY)
                    begin
                        mem_raddr  = AW'(r_m1);
                        side_next  = 1'b1;
                        state_next = S_QRD;
                    end
                    else
                    begin
                        alu_op         = ALU_FILL;
                        mem_we         = 1'b1;
                        mem_waddr      = AW'(r_m1);
                        mem_wdata.pend = 1'b1;
                        mem_wdata.pval = val_reg;
                        mem_wdata.sum  = alu_res;
                        state_next     = S_WSH;
                    end
                end
                else
                begin
                    state_next = S_WSH;
                end
            end
            S_WSH:
            begin
                l_next     = l_reg >> 1;
                r_next     = r_reg >> 1;
                h_next     = h_reg + HW'(1);
                state_next = S_WL;
            end
            S_QRD:
            begin
                acc_next   = alu_res;
                state_next = side_reg ? S_WSH : S_WR;
            end
            S_UCHK:
            begin
                if (cond)
                begin
                    mem_raddr  = AW'({k_sel, 1'b0});
                    node_next  = k_sel;
                    state_next = S_URD1;
                end
                else
                begin
                    upd_adv = 1'b1;
                end
            end
            S_URD1:
            begin
                tmp_next   = mem_rdata.sum;
                mem_raddr  = AW'({node_reg, 1'b1});
                state_next = S_URD2;
            end
            S_URD2:
            begin
                alu_a         = tmp_reg;
                mem_we        = 1'b1;
                mem_waddr     = node_reg;
                mem_wdata.sum = alu_res;
                upd_adv       = 1'b1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // push phase walks levels from the root down
        if (push_adv)
        begin
            if (!side_reg)
            begin
                side_next  = 1'b1;
                state_next = S_PCHK;
            end
            else
            begin
                side_next = 1'b0;
                if (i_reg == HW'(1))
                begin
                    h_next     = '0;
                    state_next = S_WL;
                end
                else
                begin
                    i_next     = i_reg - HW'(1);
                    state_next = S_PCHK;
                end
            end
        end

        // rebuild phase walks levels from the leaves up
        if (upd_adv)
        begin
            if (!side_reg)
            begin
                side_next  = 1'b1;
                state_next = S_UCHK;
            end
            else
            begin
                side_next = 1'b0;
                if (i_reg == HW'(LOG))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + HW'(1);
                    state_next = S_UCHK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            side_reg      <= 1'b0;
            i_reg         <= '0;
            h_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            side_reg      <= side_next;
            i_reg         <= i_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg       <= l_next;
        r_reg       <= r_next;
        l0_reg      <= l0_next;
        r0_reg      <= r0_next;
        kind_reg    <= kind_next;
        val_reg     <= val_next;
        acc_reg     <= acc_next;
        tmp_reg     <= tmp_next;
        node_reg    <= node_next;
        nw_reg      <= nw_next;
        out_sum_reg <= out_sum_next;
    end

endmodule

>>> src/rtss_checker.sv
// port-level checks for the range assign / range sum tree, bound to the top level
`include "range_assign_range_sum_tree_assert.svh"

module rtss_checker
    import rtss_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    req_type,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [SUM_W-1:0] range_sum
);

    // a stalled result holds
    `RTSS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(range_sum), "moved")

    // a query always keeps the block busy for a while
    `RTSS_ASSERT_NXT(a_query_busy, in_valid && in_ready && req_type == REQ_QUERY, !in_ready, "busy")

    // an assign never produces a result
    `RTSS_ASSERT_NXT(a_assign_silent, in_valid && in_ready && req_type == REQ_ASSIGN, !$rose(out_valid), "silent")

    // a new result only appears once the block is free again
    `RTSS_ASSERT_IMP(a_result_idle, $rose(out_valid), in_ready, "result while busy")

endmodule

bind range_assign_range_sum_tree rtss_checker u_rtss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .range_sum (range_sum)
);

>>> tb/tb_top.sv
// self-checking testbench for the range assign / range sum tree
module tb_top
    import rtss_pkg::*;
();

    typedef struct {
        logic                    kind;
        logic [IDX_W-1:0]        lo;
        logic [IDX_W-1:0]        hi;
        logic signed [VAL_W-1:0] val;
    } tree_req_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    req_type;
    logic [IDX_W-1:0]        range_start;
    logic [IDX_W-1:0]        range_end;
    logic signed [VAL_W-1:0] assign_value;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [SUM_W-1:0] range_sum;

    tree_req_t               pending_reqs[$];
    logic signed [SUM_W-1:0] sums_due[$];
    longint                  cells[DEF_SIZE];
    int                      send_gap;
    int                      recv_stall;
    int                      errors;

    range_assign_range_sum_tree u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .range_start  (range_start),
        .range_end    (range_end),
        .assign_value (assign_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .range_sum    (range_sum)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // apply one request to the flat position store, queueing the expected sum of a query
    function automatic void apply_request(tree_req_t r);
        int     top;
        longint acc;
        top = (r.hi > DEF_SIZE - 1) ? DEF_SIZE - 1 : int'(r.hi);
        acc = 0;
        for (int i = int'(r.lo); i <= top; i++)
        begin
            if (r.kind == REQ_ASSIGN)
                cells[i] = longint'(r.val);
            else
                acc += cells[i];
        end
        if (r.kind == REQ_QUERY)
            sums_due.insert(sums_due.size(), acc[SUM_W-1:0]);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return -32'sd1;
            3: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic tree_req_t make_req(logic kind, int lo, int hi,
                                           logic signed [VAL_W-1:0] val);
        tree_req_t r;
        r.kind = kind;
        r.lo   = lo[IDX_W-1:0];
        r.hi   = hi[IDX_W-1:0];
        r.val  = val;
        return r;
    endfunction

    // append one request to the pending queue
    function automatic void add_req(logic kind, int lo, int hi,
                                    logic signed [VAL_W-1:0] val);
        pending_reqs.insert(pending_reqs.size(), make_req(kind, lo, hi, val));
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            req_type     <= REQ_ASSIGN;
            range_start  <= '0;
            range_end    <= '0;
            assign_value <= '0;
            send_gap     <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_request(pending_reqs.pop_front());
            end
            if (!(in_valid && !in_ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    in_valid     <= 1'b1;
                    req_type     <= pending_reqs[0].kind;
                    range_start  <= pending_reqs[0].lo;
                    range_end    <= pending_reqs[0].hi;
                    assign_value <= pending_reqs[0].val;
                    if (pending_reqs.size() > 150 && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 18);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sums_due.size() == 0)
                begin
                    $display("%0t: unexpected transfer, got %0d", $time, range_sum);
                    errors++;
                end
                else if (sums_due[0] !== range_sum)
                begin
                    $display("%0t: range_sum expected %0d got %0d",
                             $time, sums_due[0], range_sum);
                    errors++;
                    void'(sums_due.pop_front());
                end
                else
                    void'(sums_due.pop_front());
            end
            if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (pending_reqs.size() > 150 && $urandom_range(0, 4) == 0)
                    recv_stall <= $urandom_range(1, 18);
            end
        end
    end

    initial
    begin
        int lo;
        int hi;
        errors = 0;
        for (int i = 0; i < DEF_SIZE; i++)
            cells[i] = 0;

        // directed part
        add_req(REQ_QUERY, 0, 1023, $urandom);
        add_req(REQ_ASSIGN, 0, 1023, 32'sh7fffffff);
        add_req(REQ_QUERY, 0, 1023, 32'sh80000000);
        add_req(REQ_ASSIGN, 0, 1023, 32'sh80000000);
        add_req(REQ_QUERY, 0, 1023, 0);
        add_req(REQ_QUERY, 1023, 1023, 0);
        add_req(REQ_ASSIGN, 5, 300, -32'sd1);
        add_req(REQ_QUERY, 0, 511, 0);
        add_req(REQ_QUERY, 4, 6, 0);
        add_req(REQ_ASSIGN, 600, 500, 12345);
        add_req(REQ_QUERY, 600, 500, 0);
        add_req(REQ_QUERY, 1023, 0, 0);
        add_req(REQ_ASSIGN, 0, 0, 32'sh55aa33cc);
        add_req(REQ_ASSIGN, 1023, 1023, 32'sh2a55cc33);
        add_req(REQ_QUERY, 0, 0, 0);
        add_req(REQ_QUERY, 0, 1023, -32'sd1);
        add_req(REQ_ASSIGN, 512, 512, 7);
        add_req(REQ_QUERY, 511, 513, 0);
        add_req(REQ_QUERY, 1022, 1023, 0);

        // random part, mostly short ranges so pending assignments get pushed down
        for (int n = 0; n < 1150; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    lo = $urandom_range(0, 1023);
                    hi = $urandom_range(0, 1023);
                end
                2:
                begin
                    hi = $urandom_range(0, 1022);
                    lo = $urandom_range(hi + 1, 1023);
                end
                default:
                begin
                    lo = $urandom_range(0, 1023);
                    hi = lo + $urandom_range(0, 40);
                    if (hi > 1023)
                        hi = 1023;
                end
            endcase
            add_req(1'($urandom_range(0, 1)), lo, hi, pick_value());
        end

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || sums_due.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0 && sums_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
